FILE: rtl/siph_pkg.sv
// ============================================================================
// siph_pkg
// Shared types, constants and the SipRound function for the SipHash-2-4
// stream unit.
// ============================================================================
package siph_pkg;

   localparam int WordW    = 64;
   localparam int CountW   = 4;
   localparam int LenW     = 8;
   localparam int BytesPerWord = WordW / 8;
   localparam int ReqDataW = ((WordW + CountW + 7) / 8) * 8;
   localparam int FinalRounds = 4;
   localparam int RoundCntW   = $clog2(FinalRounds);

   localparam logic [WordW-1:0] Iv0      = 64'h736f6d6570736575;
   localparam logic [WordW-1:0] Iv1      = 64'h646f72616e646f6d;
   localparam logic [WordW-1:0] Iv2      = 64'h6c7967656e657261;
   localparam logic [WordW-1:0] Iv3      = 64'h7465646279746573;
   localparam logic [WordW-1:0] FinFlip  = 64'h00000000000000ff;
   localparam logic [CountW-1:0] MaxCount = CountW'(BytesPerWord);

   // Configuration register indexes.
   localparam logic CsrKeyLow  = 1'b0;
   localparam logic CsrKeyHigh = 1'b1;

   typedef logic [3:0][WordW-1:0] lanes_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // take the input chunk into the partial word
      logic round_en;  // run one SipRound on the lanes
      logic pre_xor;   // v3 ^= m before the round
      logic post_xor;  // v0 ^= m after the round
      logic flip;      // v2 ^= 0xff after the round
      logic fin_load;  // build the length-tagged final block
      logic emit;      // register the hash and restart from the key
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic word_fill; // the offered chunk completes a 64-bit word
   } status_type;

   function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int r);
      rotl = (x << r) | (x >> (WordW - r));
   endfunction

   function automatic lanes_type sip_round(input lanes_type v);
      logic [WordW-1:0] a;
      logic [WordW-1:0] b;
      logic [WordW-1:0] c;
      logic [WordW-1:0] d;
      a = v[0];
      b = v[1];
      c = v[2];
      d = v[3];
      a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
      c = c + d; d = rotl(d, 16); d = d ^ c;
      a = a + d; d = rotl(d, 21); d = d ^ a;
      c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
      sip_round = {d, c, b, a};
   endfunction

endpackage

FILE: rtl/siphash_2_4_stream_unit.sv
// A chunk that completes no word is taken in the idle state alone; one that completes a
//   64-bit word also runs two SipRounds (ABS1, ABS2), one round per cycle.
// A last chunk adds the final block load, two absorb rounds, four finalization rounds
//   and the result register load, which waits until the output register is free.
// Throughput is set by the single shared SipRound unit; one chunk at a time.
// Reset is synchronous: both keys clear to zero and a fresh message starts.
// ============================================================================
// siphash_2_4_stream_unit
// Keyed SipHash-2-4 over a byte stream delivered in chunks of 0 to 8 bytes.
// ============================================================================
module siphash_2_4_stream_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [siph_pkg::WordW-1:0]          csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [siph_pkg::ReqDataW-1:0]       req_tdata,  // data_word[63:0], byte_count[67:64]
   input  logic                                req_tlast,  // last_item
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [siph_pkg::WordW-1:0]          rsp_tdata   // hash_value[63:0]
);

   siph_pkg::cmd_type    cmd;
   siph_pkg::status_type status;

   siph_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   siph_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .data_word  (req_tdata[siph_pkg::WordW-1:0]),
      .byte_count (req_tdata[siph_pkg::WordW +: siph_pkg::CountW]),
      .cmd        (cmd),
      .status     (status),
      .hash_value (rsp_tdata)
   );

   // A chunk that fills a word must block the next transfer while it is mixed in.
   a_busy_after_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.word_fill) |=> !req_tready)
      else $error("input taken while a completed word is being absorbed");

   // A new hash never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before its transfer");

   // The result valid rises only after the controller loaded a hash.
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.emit))
      else $error("result valid without a loaded hash");

   // Rounds never run while an input transfer is being taken.
   a_no_round_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.round_en)
      else $error("round issued in the load cycle");

endmodule

FILE: rtl/siph_ctrl.sv
// ============================================================================
// siph_ctrl
// Controller state machine: sequences chunk loads, the two compression
// rounds per word, finalization and the result handshake.
// ============================================================================
module siph_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  siph_pkg::status_type status,
   output siph_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ABS1  = 8'b0000_0010,
      ST_ABS2  = 8'b0000_0100,
      ST_FLOAD = 8'b0000_1000,
      ST_FABS1 = 8'b0001_0000,
      ST_FABS2 = 8'b0010_0000,
      ST_FRND  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic last_pend_ff, last_pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [siph_pkg::RoundCntW-1:0] rnd_ff, rnd_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      last_pend_in = last_pend_ff;
      rnd_in       = rnd_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load     = 1'b1;
               last_pend_in = req_tlast;
               if (status.word_fill) begin
                  state_in = ST_ABS1;
               end else if (req_tlast) begin
                  state_in = ST_FLOAD;
               end
            end
         end
         ST_ABS1: begin
            cmd.round_en = 1'b1;
            cmd.pre_xor  = 1'b1;
            state_in     = ST_ABS2;
         end
         ST_ABS2: begin
            cmd.round_en = 1'b1;
            cmd.post_xor = 1'b1;
            state_in     = last_pend_ff ? ST_FLOAD : ST_IDLE;
         end
         ST_FLOAD: begin
            cmd.fin_load = 1'b1;
            state_in     = ST_FABS1;
         end
         ST_FABS1: begin
            cmd.round_en = 1'b1;
            cmd.pre_xor  = 1'b1;
            state_in     = ST_FABS2;
         end
         ST_FABS2: begin
            cmd.round_en = 1'b1;
            cmd.post_xor = 1'b1;
            cmd.flip     = 1'b1;
            rnd_in       = '0;
            state_in     = ST_FRND;
         end
         ST_FRND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 1'b1;
            if (rnd_ff == siph_pkg::RoundCntW'(siph_pkg::FinalRounds - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // A finished hash may only replace the output once the old one is gone.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rnd_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         last_pend_ff <= last_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rnd_ff       <= rnd_in;
      end
   end

endmodule

FILE: rtl/siph_datapath.sv
// ============================================================================
// siph_datapath
// Key registers, lane words, partial-word packer, message length and the
// result register, driven by the controller's commands.
// ============================================================================
module siph_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [siph_pkg::WordW-1:0]          csr_wdata,
   input  logic [siph_pkg::WordW-1:0]          data_word,
   input  logic [siph_pkg::CountW-1:0]         byte_count,
   input  siph_pkg::cmd_type                   cmd,
   output siph_pkg::status_type                status,
   output logic [siph_pkg::WordW-1:0]          hash_value
);

   localparam int W = siph_pkg::WordW;

   logic [W-1:0] key_low_ff, key_low_in;
   logic [W-1:0] key_high_ff, key_high_in;
   siph_pkg::lanes_type lanes_ff, lanes_in;
   logic [W-1:0] partial_ff, partial_in;
   logic [siph_pkg::LenW-1:0] len_ff, len_in;
   logic [W-1:0] msg_ff, msg_in;
   logic [W-1:0] hash_ff, hash_in;

   logic [siph_pkg::CountW-1:0] count;
   logic [2:0]                  pos;
   logic [W-1:0]                masked;
   logic [2*W-1:0]              combined;
   logic [siph_pkg::CountW:0]   fill_sum;
   siph_pkg::lanes_type         round_in;
   siph_pkg::lanes_type         round_out;
   siph_pkg::lanes_type         restart_lanes;
   logic [W-1:0]                new_k0;
   logic [W-1:0]                new_k1;

   // Chunk packing: keep the valid low bytes and place them at the fill position.
   always_comb begin
      count = (byte_count > siph_pkg::MaxCount) ? siph_pkg::MaxCount : byte_count;
      pos   = len_ff[2:0];
      for (int i = 0; i < siph_pkg::BytesPerWord; i++) begin
         masked[8*i +: 8] = (siph_pkg::CountW'(i) < count) ? data_word[8*i +: 8] : 8'h00;
      end
      combined = {{W{1'b0}}, partial_ff} | ({{W{1'b0}}, masked} << {pos, 3'b000});
      fill_sum = {2'b00, pos} + {1'b0, count};
      status.word_fill = (fill_sum >= (siph_pkg::CountW+1)'(siph_pkg::BytesPerWord));
   end

   always_comb begin
      round_in = lanes_ff;
      if (cmd.pre_xor) begin
         round_in[3] = lanes_ff[3] ^ msg_ff;
      end
      round_out = siph_pkg::sip_round(round_in);
      if (cmd.post_xor) begin
         round_out[0] = round_out[0] ^ msg_ff;
      end
      if (cmd.flip) begin
         round_out[2] = round_out[2] ^ siph_pkg::FinFlip;
      end
   end

   // A key write restarts the message from the new key.
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_we) begin
         unique case (csr_index)
            siph_pkg::CsrKeyLow:  key_low_in  = csr_wdata;
            siph_pkg::CsrKeyHigh: key_high_in = csr_wdata;
            default: ;
         endcase
      end
      new_k0 = key_low_in;
      new_k1 = key_high_in;
      restart_lanes = {new_k1 ^ siph_pkg::Iv3, new_k0 ^ siph_pkg::Iv2,
                       new_k1 ^ siph_pkg::Iv1, new_k0 ^ siph_pkg::Iv0};
   end

   always_comb begin
      lanes_in   = lanes_ff;
      partial_in = partial_ff;
      len_in     = len_ff;
      msg_in     = msg_ff;
      hash_in    = hash_ff;
      if (cmd.load) begin
         len_in = len_ff + siph_pkg::LenW'(count);
         if (status.word_fill) begin
            msg_in     = combined[W-1:0];
            partial_in = combined[2*W-1:W];
         end else begin
            partial_in = combined[W-1:0];
         end
      end
      if (cmd.round_en) begin
         lanes_in = round_out;
      end
      if (cmd.fin_load) begin
         msg_in = partial_ff | {len_ff, {(W-siph_pkg::LenW){1'b0}}};
      end
      if (cmd.emit) begin
         hash_in = lanes_ff[0] ^ lanes_ff[1] ^ lanes_ff[2] ^ lanes_ff[3];
      end
      if (cmd.emit || csr_we) begin
         lanes_in   = restart_lanes;
         partial_in = '0;
         len_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         lanes_ff    <= {siph_pkg::Iv3, siph_pkg::Iv2, siph_pkg::Iv1, siph_pkg::Iv0};
         partial_ff  <= '0;
         len_ff      <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         lanes_ff    <= lanes_in;
         partial_ff  <= partial_in;
         len_ff      <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff  <= msg_in;
      hash_ff <= hash_in;
   end

   assign hash_value = hash_ff;

endmodule

FILE: verif/tb_siphash_2_4_stream_unit.sv
// ============================================================================
// tb_siphash_2_4_stream_unit
// Self-checking testbench for the SipHash-2-4 stream unit. Messages are fed
// as chunks of 0 to 15 claimed bytes under a set of keys. A predictor in this
// file works out every hash, and each result transfer is checked in order.
// ============================================================================
module tb_siphash_2_4_stream_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SettleCycles = 16;
   localparam int CycleLimit   = 400000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic                          csr_index = siph_pkg::CsrKeyLow;
   logic [siph_pkg::WordW-1:0]    csr_wdata = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [siph_pkg::ReqDataW-1:0] req_tdata = '0;  // data_word[63:0], byte_count[67:64]
   logic                          req_tlast = 1'b0; // last_item
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [siph_pkg::WordW-1:0]    rsp_tdata;       // hash_value[63:0]

   // Predictor state.
   logic [siph_pkg::WordW-1:0] key_lo;
   logic [siph_pkg::WordW-1:0] key_hi;
   logic [siph_pkg::WordW-1:0] lane_v [4];
   logic [siph_pkg::WordW-1:0] pend_word;
   logic [7:0]                 msg_len;
   logic [siph_pkg::WordW-1:0] pending_hashes [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   logic [siph_pkg::WordW-1:0] expected_hash;

   siphash_2_4_stream_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hashes.size() == 0) begin
            report_mismatch($sformatf("hash %h with none expected", rsp_tdata));
         end else begin
            expected_hash = pending_hashes.pop_front();
            if (rsp_tdata !== expected_hash) begin
               report_mismatch($sformatf("hash %h, expected %h", rsp_tdata, expected_hash));
            end
         end
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [siph_pkg::WordW-1:0] rotl64(
         input logic [siph_pkg::WordW-1:0] x, input int unsigned r);
      return (x << r) | (x >> (siph_pkg::WordW - r));
   endfunction

   function automatic void sip_mix();
      logic [siph_pkg::WordW-1:0] a, b, c, d;
      a = lane_v[0];
      b = lane_v[1];
      c = lane_v[2];
      d = lane_v[3];
      a = a + b; b = rotl64(b, 13); b ^= a; a = rotl64(a, 32);
      c = c + d; d = rotl64(d, 16); d ^= c;
      a = a + d; d = rotl64(d, 21); d ^= a;
      c = c + b; b = rotl64(b, 17); b ^= c; c = rotl64(c, 32);
      lane_v[0] = a;
      lane_v[1] = b;
      lane_v[2] = c;
      lane_v[3] = d;
   endfunction

   function automatic void absorb_word(input logic [siph_pkg::WordW-1:0] m);
      lane_v[3] ^= m;
      sip_mix();
      sip_mix();
      lane_v[0] ^= m;
   endfunction

   function automatic void restart_message();
      lane_v[0] = key_lo ^ siph_pkg::Iv0;
      lane_v[1] = key_hi ^ siph_pkg::Iv1;
      lane_v[2] = key_lo ^ siph_pkg::Iv2;
      lane_v[3] = key_hi ^ siph_pkg::Iv3;
      pend_word = '0;
      msg_len   = '0;
   endfunction

   function automatic void take_chunk(input logic [siph_pkg::WordW-1:0] data,
                                      input logic [siph_pkg::CountW-1:0] count,
                                      input logic last);
      int unsigned n;
      int unsigned pos;
      n   = (count > 8) ? 8 : count;
      pos = msg_len[2:0];
      for (int i = 0; i < n; i++) begin
         pend_word[8*pos +: 8] = data[8*i +: 8];
         pos++;
         if (pos == 8) begin
            absorb_word(pend_word);
            pend_word = '0;
            pos = 0;
         end
      end
      msg_len = msg_len + 8'(n);
      if (last) begin
         // The final block carries the length modulo 256 in its top byte.
         absorb_word(pend_word | {msg_len, 56'b0});
         lane_v[2] ^= siph_pkg::FinFlip;
         repeat (4) sip_mix();
         pending_hashes.push_back(lane_v[0] ^ lane_v[1] ^ lane_v[2] ^ lane_v[3]);
         restart_message();
      end
   endfunction

   // ---------------------------------------------------------------- drivers
   // Each call starts right after a rising edge, so tvalid gets one assignment
   // per time step.
   task automatic send_chunk(input logic [siph_pkg::WordW-1:0] data,
                             input logic [siph_pkg::CountW-1:0] count,
                             input logic last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= siph_pkg::ReqDataW'({count, data});
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      take_chunk(data, count, last);
   endtask

   // Holds the sender off until every hash has come out and the unit has had
   // time to finish a chunk that produces no result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_key(input logic index, input logic [siph_pkg::WordW-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == siph_pkg::CsrKeyLow) key_lo = value;
      else key_hi = value;
      restart_message();
   endtask

   function automatic logic [siph_pkg::WordW-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_zero_key_extremes();
      send_chunk('0, 4'd0, 1'b1);               // empty message
      send_chunk('1, 4'd8, 1'b1);               // exactly one word
      send_chunk('0, 4'd8, 1'b0);
      send_chunk('1, 4'd15, 1'b1);              // count saturates to eight
      send_chunk('1, 4'd3, 1'b0);               // high bytes must be ignored
      send_chunk('1, 4'd0, 1'b0);               // empty chunk mid-message
      send_chunk(64'h0123456789abcdef, 4'd7, 1'b1);
      send_chunk(rand_word(), 4'd9, 1'b0);
      send_chunk(rand_word(), 4'd1, 1'b1);
   endtask

   task automatic test_key_extremes();
      write_key(siph_pkg::CsrKeyLow, '1);
      write_key(siph_pkg::CsrKeyHigh, '1);
      send_chunk(rand_word(), 4'd5, 1'b0);
      send_chunk(rand_word(), 4'd8, 1'b1);
      write_key(siph_pkg::CsrKeyLow, '0);
      send_chunk(rand_word(), 4'd6, 1'b1);
      write_key(siph_pkg::CsrKeyLow, 64'h0706050403020100);
      write_key(siph_pkg::CsrKeyHigh, 64'h0f0e0d0c0b0a0908);
      send_chunk('0, 4'd0, 1'b1);
      send_chunk(64'h0706050403020100, 4'd8, 1'b0);
      send_chunk(64'h000e0d0c0b0a0908, 4'd7, 1'b1);
   endtask

   // A key write in the middle of a message throws away what was absorbed.
   task automatic test_key_write_restart();
      send_chunk(rand_word(), 4'd6, 1'b0);
      send_chunk(rand_word(), 4'd8, 1'b0);
      write_key(siph_pkg::CsrKeyHigh, '0);
      send_chunk(rand_word(), 4'd4, 1'b1);
   endtask

   task automatic test_random_messages(input int budget, input int idle_pct,
                                       input int stall_ratio);
      int sent;
      int chunks;
      logic [siph_pkg::CountW-1:0] count;
      write_key(siph_pkg::CsrKeyLow, rand_word());
      write_key(siph_pkg::CsrKeyHigh, rand_word());
      send_idle_pct = idle_pct;
      stall_pct     = stall_ratio;
      sent = 0;
      while (sent < budget) begin
         // Now and then a long message, so the length counter can wrap.
         chunks = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
         for (int i = 0; i < chunks; i++) begin
            count = ($urandom_range(19) < 2) ? siph_pkg::CountW'($urandom_range(9, 15))
                                             : siph_pkg::CountW'($urandom_range(0, 8));
            send_chunk(rand_word(), count, i == chunks - 1);
            sent++;
         end
         if ($urandom_range(19) == 0) drain_results();
      end
   endtask

   initial begin
      key_lo = '0;
      key_hi = '0;
      restart_message();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_zero_key_extremes();
      test_key_extremes();
      test_key_write_restart();
      test_random_messages(250, 0, 0);
      test_random_messages(250, 55, 0);
      test_random_messages(250, 0, 55);
      test_random_messages(250, 22, 22);

      drain_results();
      if (pending_hashes.size() != 0) report_mismatch("hashes never produced");
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/siph_pkg.sv
rtl/siph_ctrl.sv
rtl/siph_datapath.sv
rtl/siphash_2_4_stream_unit.sv
verif/tb_siphash_2_4_stream_unit.sv
